>>> hdl/bspc_pkg.sv
// Shared types, constants and helpers of the boost solenoid PWM controller.
// No dependencies; imported by the divider, the top level, the checker and the testbench.
package bspc_pkg;

    localparam int GEAR_SLOTS = 6;
    localparam int CFG_W      = 48;

    localparam logic [7:0] ENRICH_MIN_PRESSURE = 8'h52;
    localparam logic [9:0] IAP_LIMIT           = 10'(16'hBA00 >> 6);
    localparam logic [7:0] FULL_DUTY           = 8'd100;
    localparam logic [7:0] BYTE_MASK           = 8'hFF;

    localparam logic [2:0] REG_GEAR_MAX_BOOST  = 3'd0;
    localparam logic [2:0] REG_GEAR_GATE       = 3'd1;
    localparam logic [2:0] REG_GEAR_DUTY       = 3'd2;
    localparam logic [2:0] REG_GEAR_RETARD     = 3'd3;
    localparam logic [2:0] REG_OVERBOOST_LIMIT = 3'd4;
    localparam logic [2:0] REG_PWM_PERIOD      = 3'd5;
    localparam logic [2:0] REG_FUEL_DIVISOR    = 3'd6;
    localparam logic [2:0] REG_CONTROL_FLAGS   = 3'd7;

    typedef struct packed {
        logic        start;
        logic [15:0] dividend;
        logic [7:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] quotient;
    } div_rsp_t;

    // Byte of a per-gear register; slots past the sixth read as zero.
    function automatic logic [7:0] gear_byte(input logic [CFG_W-1:0] r, input logic [2:0] slot);
        logic [7:0] b;
        b = 8'd0;
        if (int'(slot) < GEAR_SLOTS) begin
            b = r[slot*8 +: 8] & BYTE_MASK;
        end
        return b;
    endfunction

endpackage

>>> hdl/boost_solenoid_pwm_controller.sv
// Top level of the boost solenoid PWM controller: sequencer, state and config.
// Depends on bspc_pkg and bspc_divider.
//
// Usage:
//   Each s_ transaction is one analog-conversion tick. The block answers with
//   exactly one m_ transaction carrying intake pressure, fuel enrichment,
//   solenoid pin level, total ignition retard, overboost flag and duty.
//   A small sequencer runs one serial divider for the scaled fuel enrichment
//   (only when pressure is at or above 0x52 and the fuel divisor is nonzero).
//   The PWM threshold test count < duty * period / 100 needs no division:
//   the evaluation cycle compares (count + 1) * 100 against duty * period.
//   An item runs through the evaluate step, the fuel start and wait steps
//   when it divides, and the final step; s_ready is high only while the
//   sequencer is idle, so a new tick waits until the last one leaves the final step.
//   The result sits in an output register: the next tick is accepted while
//   a result still waits, and a stalled receiver holds m_ fields steady. A
//   finished item waits in the final step until the output register frees.
//   The config port writes one register per cycle with cfg_wr_en; write only
//   while the block is idle.
//   Reset (aresetn low, synchronous) clears the PWM counter, held duty and
//   pin level, reloads every register with its default and drops m_valid.
module boost_solenoid_pwm_controller #(
    parameter int NUM_GEARS = 6
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_wdata,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [9:0]  s_boost_sample,
    input  logic [3:0]  s_gear,
    input  logic [7:0]  s_iap_mapped,
    input  logic [7:0]  s_retard_mapped,
    input  logic [7:0]  s_enrich_mapped,
    input  logic [15:0] s_tps_fuel,
    input  logic [7:0]  s_base_retard,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [9:0]  m_iap_pressure,
    output logic [7:0]  m_fuel_add,
    output logic        m_solenoid_pin,
    output logic [7:0]  m_ign_retard_total,
    output logic        m_overboost,
    output logic [6:0]  m_duty_percent
);
    import bspc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE      = 5'b00001,
        S_EVAL      = 5'b00010,
        S_FUEL      = 5'b00100,
        S_FUEL_WAIT = 5'b01000,
        S_FINISH    = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [47:0] gear_max_boost_reg, gear_gate_reg, gear_duty_reg, gear_retard_reg;
    logic [7:0]  overboost_limit_reg, pwm_period_reg, fuel_divisor_reg;
    logic [1:0]  control_flags_reg;

    // block state
    logic [7:0]  pwm_count_reg, pwm_count_next;
    logic [6:0]  duty_level_reg;
    logic        pin_level_reg;

    // captured transaction
    logic [9:0]  sample_reg;
    logic [3:0]  gear_reg;
    logic [7:0]  iap_m_reg, ret_m_reg, enr_m_reg, tps_hi_reg, base_reg;

    // per-item working values
    logic [9:0]  iap_reg;
    logic [7:0]  fuel_reg;
    logic [7:0]  retard_reg;
    logic        ob_reg;
    logic        fuel_div_reg;
    logic [15:0] fuel_prod_reg;

    // output register
    logic        m_valid_reg;
    logic [9:0]  m_iap_reg;
    logic [7:0]  m_fuel_reg, m_retard_reg;
    logic        m_pin_reg, m_ob_reg;
    logic [6:0]  m_duty_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [7:0]  pressure;
    logic        gear_ok;
    logic [2:0]  slot;
    logic [7:0]  gd_byte;
    logic [6:0]  duty_sel;
    logic [7:0]  gret;
    logic [9:0]  iap_raw;
    logic [7:0]  cnt_inc;
    logic [14:0] duty_prod;
    logic [15:0] cnt_scaled;
    logic        enabled;
    logic        out_free;
    logic        active;

    assign enabled  = control_flags_reg[0];
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign pressure = sample_reg[9:2];

    // Evaluate the item: counter advance, gear lookups, duty pick, clamps.
    always_comb begin
        cnt_inc        = pwm_count_reg + 8'd1;
        pwm_count_next = (cnt_inc >= pwm_period_reg) ? 8'd0 : cnt_inc;

        gear_ok  = (gear_reg >= 4'd1) && (int'(gear_reg) <= NUM_GEARS);
        slot     = gear_ok ? 3'(gear_reg - 4'd1) : 3'd0;
        gd_byte  = gear_byte(gear_duty_reg, slot);
        if (gd_byte > FULL_DUTY) begin
            gd_byte = FULL_DUTY;
        end
        gret = gear_byte(gear_retard_reg, slot);

        if (!gear_ok) begin
            duty_sel = 7'd0;
        end else if (pressure >= gear_byte(gear_max_boost_reg, slot)) begin
            duty_sel = 7'd0;
        end else if (pressure > gear_byte(gear_gate_reg, slot)) begin
            duty_sel = gd_byte[6:0];
        end else begin
            duty_sel = FULL_DUTY[6:0];
        end

        iap_raw = {iap_m_reg, 2'b00};
        if (iap_raw > IAP_LIMIT) begin
            iap_raw = IAP_LIMIT;
        end

        // count < floor(duty * period / 100) holds exactly when
        // (count + 1) * 100 <= duty * period
        duty_prod  = duty_sel * pwm_period_reg;
        cnt_scaled = (16'(pwm_count_next) + 16'd1) * 16'(FULL_DUTY);
        active     = (duty_sel != 7'd0) && (cnt_scaled <= {1'b0, duty_prod});
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                if ((pressure >= ENRICH_MIN_PRESSURE) && (fuel_divisor_reg != 8'd0)) begin
                    state_next = S_FUEL;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_FUEL:      state_next = S_FUEL_WAIT;
            S_FUEL_WAIT: begin
                if (div_rsp.done) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // Drive the serial divider with the fuel scaling.
    always_comb begin
        div_req.start    = (state_reg == S_FUEL);
        div_req.dividend = fuel_prod_reg;
        div_req.divisor  = fuel_divisor_reg;
    end

    bspc_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Control state, configuration and block state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= S_IDLE;
            m_valid_reg         <= 1'b0;
            pwm_count_reg       <= 8'd0;
            duty_level_reg      <= 7'd0;
            pin_level_reg       <= 1'b0;
            gear_max_boost_reg  <= 48'hA6A6A6988B81;
            gear_gate_reg       <= 48'h707070707070;
            gear_duty_reg       <= 48'h503C32282828;
            gear_retard_reg     <= 48'h020202020201;
            overboost_limit_reg <= 8'd177;
            pwm_period_reg      <= 8'd25;
            fuel_divisor_reg    <= 8'd254;
            control_flags_reg   <= 2'd2;
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_GEAR_MAX_BOOST:  gear_max_boost_reg  <= cfg_wdata;
                    REG_GEAR_GATE:       gear_gate_reg       <= cfg_wdata;
                    REG_GEAR_DUTY:       gear_duty_reg       <= cfg_wdata;
                    REG_GEAR_RETARD:     gear_retard_reg     <= cfg_wdata;
                    REG_OVERBOOST_LIMIT: overboost_limit_reg <= cfg_wdata[7:0];
                    REG_PWM_PERIOD:      pwm_period_reg      <= cfg_wdata[7:0];
                    REG_FUEL_DIVISOR:    fuel_divisor_reg    <= cfg_wdata[7:0];
                    REG_CONTROL_FLAGS:   control_flags_reg   <= cfg_wdata[1:0];
                    default:             ;
                endcase
            end

            // pin keeps the duty from before the overboost forcing
            if (state_reg == S_EVAL) begin
                pwm_count_reg <= pwm_count_next;
                if (enabled) begin
                    duty_level_reg <= duty_sel;
                    pin_level_reg  <= (active == control_flags_reg[1]);
                end
            end

            if ((state_reg == S_FINISH) && out_free) begin
                m_valid_reg <= 1'b1;
                if (ob_reg) begin
                    duty_level_reg <= 7'd0;
                end
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            sample_reg <= s_boost_sample;
            gear_reg   <= s_gear;
            iap_m_reg  <= s_iap_mapped;
            ret_m_reg  <= s_retard_mapped;
            enr_m_reg  <= s_enrich_mapped;
            tps_hi_reg <= s_tps_fuel[15:8];
            base_reg   <= s_base_retard;
        end

        if (state_reg == S_EVAL) begin
            iap_reg       <= iap_raw;
            ob_reg        <= (pressure >= overboost_limit_reg);
            fuel_prod_reg <= enr_m_reg * tps_hi_reg;
            fuel_div_reg  <= (fuel_divisor_reg != 8'd0);
            if (pressure < ENRICH_MIN_PRESSURE) begin
                fuel_reg <= 8'd0;
            end else begin
                fuel_reg <= enr_m_reg;
            end
            if (enabled) begin
                retard_reg <= gret + base_reg + ret_m_reg;
            end else begin
                retard_reg <= base_reg + ret_m_reg;
            end
        end

        if ((state_reg == S_FUEL_WAIT) && div_rsp.done && fuel_div_reg) begin
            fuel_reg <= div_rsp.quotient[7:0];
        end

        if ((state_reg == S_FINISH) && out_free) begin
            m_iap_reg    <= iap_reg;
            m_fuel_reg   <= fuel_reg;
            m_pin_reg    <= pin_level_reg;
            m_retard_reg <= retard_reg;
            m_ob_reg     <= ob_reg;
            m_duty_reg   <= ob_reg ? 7'd0 : duty_level_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_iap_pressure     = m_iap_reg;
    assign m_fuel_add         = m_fuel_reg;
    assign m_solenoid_pin     = m_pin_reg;
    assign m_ign_retard_total = m_retard_reg;
    assign m_overboost        = m_ob_reg;
    assign m_duty_percent     = m_duty_reg;

endmodule

>>> hdl/bspc_divider.sv
// Restoring serial divider, one quotient bit per cycle, 16 by 8 bits.
// Depends on bspc_pkg for the request and response structs.
module bspc_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  bspc_pkg::div_req_t req,
    output bspc_pkg::div_rsp_t rsp
);
    import bspc_pkg::*;

    logic [15:0] quo_reg, quo_next;
    logic [7:0]  rem_reg, rem_next;
    logic [7:0]  divisor_reg;
    logic [3:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [8:0]  trial;
    logic        ge;

    // Shift in the next dividend bit and subtract when it fits.
    always_comb begin
        trial    = {rem_reg, quo_reg[15]};
        ge       = (trial >= {1'b0, divisor_reg});
        rem_next = ge ? 8'(trial - {1'b0, divisor_reg}) : trial[7:0];
        quo_next = {quo_reg[14:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 4'd0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg     <= req.dividend;
            rem_reg     <= 8'd0;
            divisor_reg <= req.divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

>>> dv/bspc_tick_checker.sv
`timescale 1ns / 1ps
// Result checker of the boost solenoid PWM controller: shadows the registers from
// the config port, predicts one report per accepted tick and compares in order.
// Depends on bspc_pkg for register indexes and limits.
module bspc_tick_checker #(
    parameter int NUM_GEARS = 6
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [9:0]  s_boost_sample,
    input  logic [3:0]  s_gear,
    input  logic [7:0]  s_iap_mapped,
    input  logic [7:0]  s_retard_mapped,
    input  logic [7:0]  s_enrich_mapped,
    input  logic [15:0] s_tps_fuel,
    input  logic [7:0]  s_base_retard,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [9:0]  m_iap_pressure,
    input  logic [7:0]  m_fuel_add,
    input  logic        m_solenoid_pin,
    input  logic [7:0]  m_ign_retard_total,
    input  logic        m_overboost,
    input  logic [6:0]  m_duty_percent,
    output int          errors,
    output int          outstanding,
    output int          reports_checked
);
    import bspc_pkg::*;

    localparam logic [47:0] MAX_BOOST_DEFAULT = 48'hA6A6A6988B81;
    localparam logic [47:0] GATE_DEFAULT      = 48'h707070707070;
    localparam logic [47:0] DUTY_DEFAULT      = 48'h503C32282828;
    localparam logic [47:0] RETARD_DEFAULT    = 48'h020202020201;

    typedef struct packed {
        logic [9:0] iap;
        logic [7:0] fuel;
        logic       pin;
        logic [7:0] retard;
        logic       ob;
        logic [6:0] duty;
    } tick_report_t;

    tick_report_t expected_reports[$];

    logic [47:0] max_boost_tab, gate_tab, duty_tab, retard_tab;
    logic [7:0]  ob_limit, pwm_period, fuel_div;
    logic [1:0]  ctrl;
    logic [7:0]  pwm_count;
    logic [6:0]  held_duty;
    logic        pin_level;

    int errs     = 0;
    int pend     = 0;
    int compared = 0;

    assign errors          = errs;
    assign outstanding     = pend;
    assign reports_checked = compared;

    function automatic int gear_slot_byte(input logic [47:0] regv, input int slot);
        return int'((regv >> (8 * slot)) & 48'hFF);
    endfunction

    task automatic check_field(input string name, input logic [9:0] want_v, got_v);
        if (got_v !== want_v) begin
            errs++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
        end
    endtask

    // Advance the PWM counter, held duty and pin for one tick and build its report.
    task automatic predict_report(
        input  logic [9:0]  sample,
        input  logic [3:0]  gear,
        input  logic [7:0]  iap_m,
        input  logic [7:0]  ret_m,
        input  logic [7:0]  enr_m,
        input  logic [15:0] tps,
        input  logic [7:0]  base,
        output tick_report_t r
    );
        logic [7:0] pressure;
        int         slot, gd, gret;
        logic       active;
        pressure = sample[9:2];

        pwm_count = pwm_count + 8'd1;
        if (pwm_count >= pwm_period) begin
            pwm_count = 8'd0;
        end

        if ({iap_m, 2'b00} > IAP_LIMIT) begin
            r.iap = IAP_LIMIT;
        end else begin
            r.iap = {iap_m, 2'b00};
        end

        if (pressure < ENRICH_MIN_PRESSURE) begin
            r.fuel = 8'd0;
        end else if (fuel_div == 8'd0) begin
            r.fuel = enr_m;
        end else begin
            r.fuel = 8'((int'(enr_m) * int'(tps[15:8])) / int'(fuel_div));
        end

        if (ctrl[0]) begin
            if (gear >= 4'd1 && int'(gear) <= NUM_GEARS) begin
                slot = int'(gear) - 1;
                gd   = gear_slot_byte(duty_tab, slot);
                if (gd > int'(FULL_DUTY)) begin
                    gd = int'(FULL_DUTY);
                end
                gret = gear_slot_byte(retard_tab, slot);
                if (int'(pressure) >= gear_slot_byte(max_boost_tab, slot)) begin
                    held_duty = 7'd0;
                end else if (int'(pressure) > gear_slot_byte(gate_tab, slot)) begin
                    held_duty = 7'(gd);
                end else begin
                    held_duty = 7'(FULL_DUTY);
                end
            end else begin
                gret      = gear_slot_byte(retard_tab, 0);
                held_duty = 7'd0;
            end
            active = (held_duty != 7'd0) &&
                     (int'(pwm_count) < (int'(held_duty) * int'(pwm_period)) / int'(FULL_DUTY));
            pin_level = (active == ctrl[1]);
            r.retard  = 8'(gret + int'(base) + int'(ret_m));
        end else begin
            r.retard = 8'(int'(base) + int'(ret_m));
        end

        // overboost clears the held duty after the pin has been driven
        r.ob = (pressure >= ob_limit);
        if (r.ob) begin
            held_duty = 7'd0;
        end
        r.pin  = pin_level;
        r.duty = held_duty;
    endtask

    always @(posedge aclk) begin : watch
        tick_report_t want, got;
        if (!aresetn) begin
            max_boost_tab = MAX_BOOST_DEFAULT;
            gate_tab      = GATE_DEFAULT;
            duty_tab      = DUTY_DEFAULT;
            retard_tab    = RETARD_DEFAULT;
            ob_limit      = 8'd177;
            pwm_period    = 8'd25;
            fuel_div      = 8'd254;
            ctrl          = 2'd2;
            pwm_count     = 8'd0;
            held_duty     = 7'd0;
            pin_level     = 1'b0;
            expected_reports.delete();
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_iap_pressure, m_fuel_add, m_solenoid_pin, m_ign_retard_total,
                        m_overboost, m_duty_percent};
                if (expected_reports.size() == 0) begin
                    errs++;
                    $display("%0t: report with no tick waiting, expected none, actual %h",
                             $time, got);
                end else begin
                    want = expected_reports.pop_front();
                    check_field("iap_pressure", want.iap, got.iap);
                    check_field("fuel_add", want.fuel, got.fuel);
                    check_field("solenoid_pin", want.pin, got.pin);
                    check_field("ign_retard_total", want.retard, got.retard);
                    check_field("overboost", want.ob, got.ob);
                    check_field("duty_percent", want.duty, got.duty);
                    compared++;
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_GEAR_MAX_BOOST:  max_boost_tab = cfg_wdata;
                    REG_GEAR_GATE:       gate_tab      = cfg_wdata;
                    REG_GEAR_DUTY:       duty_tab      = cfg_wdata;
                    REG_GEAR_RETARD:     retard_tab    = cfg_wdata;
                    REG_OVERBOOST_LIMIT: ob_limit      = cfg_wdata[7:0];
                    REG_PWM_PERIOD:      pwm_period    = cfg_wdata[7:0];
                    REG_FUEL_DIVISOR:    fuel_div      = cfg_wdata[7:0];
                    REG_CONTROL_FLAGS:   ctrl          = cfg_wdata[1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                predict_report(s_boost_sample, s_gear, s_iap_mapped, s_retard_mapped,
                               s_enrich_mapped, s_tps_fuel, s_base_retard, want);
                expected_reports.push_back(want);
            end
        end
        pend = expected_reports.size();
    end

endmodule

>>> dv/tb_boost_solenoid_pwm_controller.sv
`timescale 1ns / 1ps
// Testbench top of the boost solenoid PWM controller: clock, reset, register writes,
// tick stimulus, output back-pressure and the verdict.
// Depends on bspc_pkg, the controller RTL and bspc_tick_checker.
module tb_boost_solenoid_pwm_controller;
    import bspc_pkg::*;

    localparam int GEARS           = 6;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int PHASES          = 8;
    localparam int TICKS_PER_PHASE = 190;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 60;

    // control_flags bits
    localparam logic [47:0] DUTY_ON      = 48'd1;
    localparam logic [47:0] NON_INVERTED = 48'd2;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [47:0] cfg_wdata;
    logic        s_valid, s_ready;
    logic [9:0]  s_boost_sample;
    logic [3:0]  s_gear;
    logic [7:0]  s_iap_mapped, s_retard_mapped, s_enrich_mapped, s_base_retard;
    logic [15:0] s_tps_fuel;
    logic        m_valid, m_ready;
    logic [9:0]  m_iap_pressure;
    logic [7:0]  m_fuel_add, m_ign_retard_total;
    logic        m_solenoid_pin, m_overboost;
    logic [6:0]  m_duty_percent;

    int errors, outstanding, reports_checked;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int cycles         = 0;
    int ticks_sent     = 0;

    // copy of what was written, used to aim pressures at the thresholds
    logic [47:0] reg_shadow [8];

    boost_solenoid_pwm_controller #(.NUM_GEARS(GEARS)) dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_boost_sample     (s_boost_sample),
        .s_gear             (s_gear),
        .s_iap_mapped       (s_iap_mapped),
        .s_retard_mapped    (s_retard_mapped),
        .s_enrich_mapped    (s_enrich_mapped),
        .s_tps_fuel         (s_tps_fuel),
        .s_base_retard      (s_base_retard),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_iap_pressure     (m_iap_pressure),
        .m_fuel_add         (m_fuel_add),
        .m_solenoid_pin     (m_solenoid_pin),
        .m_ign_retard_total (m_ign_retard_total),
        .m_overboost        (m_overboost),
        .m_duty_percent     (m_duty_percent)
    );

    bspc_tick_checker #(.NUM_GEARS(GEARS)) tick_check (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_boost_sample     (s_boost_sample),
        .s_gear             (s_gear),
        .s_iap_mapped       (s_iap_mapped),
        .s_retard_mapped    (s_retard_mapped),
        .s_enrich_mapped    (s_enrich_mapped),
        .s_tps_fuel         (s_tps_fuel),
        .s_base_retard      (s_base_retard),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_iap_pressure     (m_iap_pressure),
        .m_fuel_add         (m_fuel_add),
        .m_solenoid_pin     (m_solenoid_pin),
        .m_ign_retard_total (m_ign_retard_total),
        .m_overboost        (m_overboost),
        .m_duty_percent     (m_duty_percent),
        .errors             (errors),
        .outstanding        (outstanding),
        .reports_checked    (reports_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Watchdog: end the run once the cycle count reaches CYCLE_LIMIT.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d reports still owed",
                     $time, cycles, outstanding);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side back-pressure. A bump of hold_req starts one long hold-off,
    // counted here, while the sender keeps offering ticks.
    initial begin : receiver
        int hold_seen, hold_left;
        m_ready   = 1'b0;
        hold_seen = 0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= (int'($urandom_range(99, 0)) >= recv_stall_pct);
            end
        end
    end

    // Write one register; call at a falling edge, returns at the next one with the
    // write enable still high so back-to-back writes keep it steady.
    task automatic set_reg(input logic [2:0] idx, input logic [47:0] val);
        cfg_wr_en      <= 1'b1;
        cfg_index      <= idx;
        cfg_wdata      <= val;
        reg_shadow[idx] = val;
        @(negedge aclk);
    endtask

    // Offer one tick at a falling edge and hold it until the block takes it.
    task automatic offer_tick(
        input logic [9:0]  sample,
        input logic [3:0]  gear,
        input logic [7:0]  iap_m,
        input logic [7:0]  ret_m,
        input logic [7:0]  enr_m,
        input logic [15:0] tps,
        input logic [7:0]  base
    );
        s_valid         <= 1'b1;
        s_boost_sample  <= sample;
        s_gear          <= gear;
        s_iap_mapped    <= iap_m;
        s_retard_mapped <= ret_m;
        s_enrich_mapped <= enr_m;
        s_tps_fuel      <= tps;
        s_base_retard   <= base;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        ticks_sent++;
    endtask

    // Drop valid and wait until every report owed has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
    endtask

    function automatic logic [47:0] gear_bytes(input int lo, input int hi);
        logic [47:0] v;
        for (int i = 0; i < 6; i++) begin
            v[i*8 +: 8] = 8'($urandom_range(hi, lo));
        end
        return v;
    endfunction

    // One register setting per phase; the extremes sit in phases 1 and 2.
    task automatic load_settings(input int ph);
        logic [47:0] v [8];
        v[REG_GEAR_MAX_BOOST]  = gear_bytes(128, 200);
        v[REG_GEAR_GATE]       = gear_bytes(80, 140);
        v[REG_GEAR_DUTY]       = gear_bytes(0, 120);
        v[REG_GEAR_RETARD]     = gear_bytes(0, 255);
        v[REG_OVERBOOST_LIMIT] = 48'($urandom_range(230, 140));
        v[REG_PWM_PERIOD]      = 48'($urandom_range(60, 1));
        v[REG_FUEL_DIVISOR]    = 48'($urandom_range(255, 1));
        v[REG_CONTROL_FLAGS]   = DUTY_ON | NON_INVERTED;
        case (ph)
            1: begin
                // every register but the control flags zero: overboost on every tick, counter pinned at 0
                v[REG_GEAR_MAX_BOOST]  = '0;
                v[REG_GEAR_GATE]       = '0;
                v[REG_GEAR_DUTY]       = '0;
                v[REG_GEAR_RETARD]     = '0;
                v[REG_OVERBOOST_LIMIT] = '0;
                v[REG_PWM_PERIOD]      = '0;
                v[REG_FUEL_DIVISOR]    = '0;
            end
            2: begin
                // every register but the control flags full: duty bytes saturate at 100
                v[REG_GEAR_MAX_BOOST]  = {6{8'hFF}};
                v[REG_GEAR_GATE]       = {6{8'hFF}};
                v[REG_GEAR_DUTY]       = {6{8'hFF}};
                v[REG_GEAR_RETARD]     = {6{8'hFF}};
                v[REG_OVERBOOST_LIMIT] = 48'd255;
                v[REG_PWM_PERIOD]      = 48'd255;
                v[REG_FUEL_DIVISOR]    = 48'd255;
            end
            3: begin
                v[REG_GEAR_MAX_BOOST]  = {16'($urandom), $urandom};
                v[REG_GEAR_GATE]       = {16'($urandom), $urandom};
                v[REG_GEAR_DUTY]       = {16'($urandom), $urandom};
                v[REG_GEAR_RETARD]     = {16'($urandom), $urandom};
                v[REG_OVERBOOST_LIMIT] = 48'($urandom_range(255, 0));
                v[REG_PWM_PERIOD]      = 48'($urandom_range(255, 0));
                v[REG_FUEL_DIVISOR]    = 48'($urandom_range(255, 0));
                v[REG_CONTROL_FLAGS]   = 48'($urandom_range(3, 0));
            end
            4: begin
                v[REG_PWM_PERIOD]    = 48'd100;
                v[REG_FUEL_DIVISOR]  = '0;
                v[REG_CONTROL_FLAGS] = DUTY_ON;
            end
            5: v[REG_PWM_PERIOD] = 48'd25;
            // duty control off: held duty and pin carry over from phase 5
            6: v[REG_CONTROL_FLAGS] = ($urandom_range(1, 0) != 0) ? NON_INVERTED : '0;
            7: v[REG_PWM_PERIOD] = 48'd1;
            default: ;
        endcase
        for (int i = 0; i < 8; i++) begin
            set_reg(3'(i), v[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Random tick; most pressures land on a threshold of the current gear or
    // the enrichment and overboost limits, one count either side.
    task automatic random_tick();
        logic [3:0] g;
        logic [7:0] iap_m;
        int         slot, aim, q;
        if ($urandom_range(99, 0) < 80) begin
            g = 4'($urandom_range(GEARS, 1));
        end else begin
            g = 4'($urandom_range(15, 0));
        end
        slot = (g >= 4'd1 && int'(g) <= GEARS) ? int'(g) - 1 : 0;
        case ($urandom_range(5, 0))
            0:       aim = int'(reg_shadow[REG_GEAR_MAX_BOOST][slot*8 +: 8]);
            1:       aim = int'(reg_shadow[REG_GEAR_GATE][slot*8 +: 8]);
            2:       aim = int'(reg_shadow[REG_OVERBOOST_LIMIT][7:0]);
            3:       aim = int'(ENRICH_MIN_PRESSURE);
            default: aim = -1;
        endcase
        if (aim < 0) begin
            q = int'($urandom_range(255, 0));
        end else begin
            q = aim + int'($urandom_range(2, 0)) - 1;
            if (q < 0) q = 0;
            if (q > 255) q = 255;
        end
        // keep some intake values around the 744 clamp
        if ($urandom_range(3, 0) == 0) begin
            iap_m = 8'($urandom_range(190, 182));
        end else begin
            iap_m = 8'($urandom);
        end
        offer_tick({8'(q), 2'($urandom)}, g, iap_m, 8'($urandom), 8'($urandom),
                   16'($urandom), 8'($urandom));
    endtask

    // Short directed sweep: field extremes, thresholds, every gear, both polarities.
    task automatic directed_ticks();
        // reset settings: duty control off
        offer_tick(10'd0, 4'd0, 8'd0, 8'd0, 8'd0, 16'h0000, 8'd0);
        offer_tick(10'h3FF, 4'hF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
        offer_tick(10'h147, 4'd1, 8'd186, 8'd1, 8'd200, 16'h8000, 8'd2);
        offer_tick(10'h148, 4'd2, 8'd187, 8'd3, 8'd200, 16'h80FF, 8'd4);
        wait_drained();
        set_reg(REG_CONTROL_FLAGS, DUTY_ON | NON_INVERTED);
        set_reg(REG_FUEL_DIVISOR, '0);
        cfg_wr_en <= 1'b0;
        // every gear slot plus the out-of-range ones, below the gate
        for (int g = 0; g <= 8; g++) begin
            offer_tick({8'h40, 2'b01}, (g == 8) ? 4'hF : 4'(g), 8'(g * 20),
                       8'(g), 8'(30 + g), 16'(g << 12), 8'(250 - g));
        end
        // gear 1 gate and maximum boost edges; plain enrichment with divisor 0
        offer_tick({8'h70, 2'b11}, 4'd1, 8'd100, 8'd5, 8'd77, 16'h1234, 8'd9);
        offer_tick({8'h71, 2'b00}, 4'd1, 8'd100, 8'd5, 8'd78, 16'h4321, 8'd9);
        offer_tick({8'h80, 2'b10}, 4'd1, 8'd100, 8'd5, 8'd79, 16'hFF00, 8'd9);
        offer_tick({8'h81, 2'b01}, 4'd1, 8'd100, 8'd5, 8'd80, 16'h00FF, 8'd9);
        // overboost limit exactly and one below
        offer_tick({8'd176, 2'b11}, 4'd3, 8'd150, 8'd20, 8'd90, 16'hA5A5, 8'd40);
        offer_tick({8'd177, 2'b00}, 4'd3, 8'd150, 8'd20, 8'd90, 16'h5A5A, 8'd40);
        wait_drained();
        set_reg(REG_CONTROL_FLAGS, DUTY_ON);
        cfg_wr_en <= 1'b0;
        offer_tick({8'h30, 2'b00}, 4'd4, 8'd10, 8'd0, 8'd0, 16'h0100, 8'd0);
        offer_tick({8'h30, 2'b11}, 4'd6, 8'd10, 8'd0, 8'd0, 16'h0100, 8'd0);
    endtask

    initial begin
        aresetn         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = '0;
        cfg_wdata       = '0;
        s_valid         = 1'b0;
        s_boost_sample  = '0;
        s_gear          = '0;
        s_iap_mapped    = '0;
        s_retard_mapped = '0;
        s_enrich_mapped = '0;
        s_tps_fuel      = '0;
        s_base_retard   = '0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        directed_ticks();

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            load_settings(ph);
            // idle mix per phase: none, sender, receiver, both
            case (ph)
                1, 4:    begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2, 6:    begin send_idle_pct = 0;  recv_stall_pct = 70; end
                3, 7:    begin send_idle_pct = 18; recv_stall_pct = 18; end
                default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            for (int n = 0; n < TICKS_PER_PHASE; n++) begin
                if (ph == 5 && n == 10) begin
                    hold_req++;
                end
                if ($urandom_range(99, 0) < send_idle_pct) begin
                    s_valid <= 1'b0;
                    do @(negedge aclk); while ($urandom_range(99, 0) < send_idle_pct);
                end
                random_tick();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Summary: %0d ticks, %0d reports compared over %0d register settings.",
                 ticks_sent, reports_checked, PHASES + 3);
        $display("Covered duty control on and off, both pin polarities, gaps, stalls %s%0d",
                 "and a hold-off of cycles: ", HOLD_CYCLES);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/bspc_pkg.sv
hdl/bspc_divider.sv
hdl/boost_solenoid_pwm_controller.sv
dv/bspc_tick_checker.sv
dv/tb_boost_solenoid_pwm_controller.sv
